// ===== rtl/gf2alu_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the gf2 polynomial alu
// no dependencies

package gf2alu_pkg;

  // default operand width in bits
  localparam int GF2ALU_WIDTH = 32;

  // reduction / multiply steps folded into one pipeline stage
  localparam int GF2ALU_STEPS_PER_STAGE = 8;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_MUL = 2'd1,
    FUNC_REM = 2'd2,
    FUNC_RSV = 2'd3
  } func_t;

  // control that travels down the pipe next to the data
  typedef struct packed {
    logic  valid;
    func_t func;
    logic  err;
  } ctl_t;

endpackage

// ===== rtl/gf2_polynomial_alu.sv =====
`timescale 1ns / 1ps
// gf2 polynomial alu top level: front stage plus a chain of step stages
// depends on gf2alu_pkg, gf2alu_prep, gf2alu_stage

// Polynomial ALU over GF(2): bit i of an operand is the coefficient of x^i. in_func selects
// add (xor), carry-less multiply (2*WIDTH-1 bit product) or a mod b; a zero divisor gives
// result 0 with out_div_by_zero set, and the unused code gives 0. The block is a fully
// pipelined datapath: one front stage (divisor degree and alignment) followed by
// ceil(WIDTH/8) stages that each do up to eight multiply or reduction steps; one request
// can be accepted in every cycle while the output is not stalled. The whole pipe advances
// together; it stops only while the result at the output is not taken, so in_ready follows
// out_ready combinationally. There is no state beyond the pipeline registers and nothing
// to configure.

module gf2_polynomial_alu
  import gf2alu_pkg::*;
#(
  parameter int WIDTH = GF2ALU_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [WIDTH-1:0]   in_a,
  input  logic [WIDTH-1:0]   in_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2*WIDTH-2:0] out_result,
  output logic               out_div_by_zero
);

  localparam int SHW    = $clog2(WIDTH);
  localparam int AW     = 2 * WIDTH - 1;
  localparam int STEP   = GF2ALU_STEPS_PER_STAGE;
  localparam int NSTAGE = (WIDTH + STEP - 1) / STEP;

  // index 0 is the front stage output, index NSTAGE the last step stage
  ctl_t             ctl_s [0:NSTAGE];
  logic [WIDTH-1:0] opa_s [0:NSTAGE];
  logic [WIDTH-1:0] opb_s [0:NSTAGE];
  logic [SHW-1:0]   sh_s  [0:NSTAGE];
  logic [AW-1:0]    acc_s [0:NSTAGE];

  // global advance: the pipe moves unless a finished result is held at the output
  logic en;
  assign en       = !ctl_s[NSTAGE].valid || out_ready;
  assign in_ready = en;

  gf2alu_prep #(
    .WIDTH (WIDTH),
    .SHW   (SHW),
    .AW    (AW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_a     (in_a),
    .in_b     (in_b),
    .ctl_r    (ctl_s[0]),
    .opa_r    (opa_s[0]),
    .opb_r    (opb_s[0]),
    .sh_r     (sh_s[0]),
    .acc_r    (acc_s[0])
  );

  // each stage covers steps FIRST .. FIRST+STEPS-1; the last may be shorter
  for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
    localparam int FIRST = j * STEP;
    localparam int STEPS = (WIDTH - FIRST < STEP) ? (WIDTH - FIRST) : STEP;

    gf2alu_stage #(
      .WIDTH (WIDTH),
      .FIRST (FIRST),
      .STEPS (STEPS),
      .SHW   (SHW),
      .AW    (AW)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_s[j]),
      .opa_i (opa_s[j]),
      .opb_i (opb_s[j]),
      .sh_i  (sh_s[j]),
      .acc_i (acc_s[j]),
      .ctl_r (ctl_s[j+1]),
      .opa_r (opa_s[j+1]),
      .opb_r (opb_s[j+1]),
      .sh_r  (sh_s[j+1]),
      .acc_r (acc_s[j+1])
    );
  end

  // the last stage register is the output register
  assign out_valid       = ctl_s[NSTAGE].valid;
  assign out_result      = acc_s[NSTAGE];
  assign out_div_by_zero = ctl_s[NSTAGE].err;

endmodule

// ===== rtl/gf2alu_prep.sv =====
`timescale 1ns / 1ps
// front stage: decodes the operation, finds the divisor degree and left-aligns the divisor
// depends on gf2alu_pkg

module gf2alu_prep
  import gf2alu_pkg::*;
#(
  parameter int WIDTH = GF2ALU_WIDTH,
  parameter int SHW   = $clog2(WIDTH),
  parameter int AW    = 2 * WIDTH - 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  input  logic [WIDTH-1:0] in_a,
  input  logic [WIDTH-1:0] in_b,
  output ctl_t             ctl_r,
  output logic [WIDTH-1:0] opa_r,
  output logic [WIDTH-1:0] opb_r,
  output logic [SHW-1:0]   sh_r,
  output logic [AW-1:0]    acc_r
);

  ctl_t             ctl_nxt;
  logic [WIDTH-1:0] opb_nxt;
  logic [SHW-1:0]   sh_nxt;
  logic [AW-1:0]    acc_nxt;
  logic [SHW-1:0]   dy;
  logic             b_zero;
  func_t            func;

  assign func   = func_t'(in_func);
  assign b_zero = (in_b == '0);

  // degree of the divisor: position of its highest set bit
  always_comb begin
    dy = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (in_b[i]) begin
        dy = SHW'(i);
      end
    end
  end

  // shift that brings the divisor's leading term to the top bit
  assign sh_nxt = SHW'(WIDTH - 1) - dy;

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.func  = func;
    ctl_nxt.err   = 1'b0;
    opb_nxt       = in_b;
    acc_nxt       = '0;
    unique case (func)
      FUNC_ADD: begin
        acc_nxt = AW'(in_a ^ in_b);
      end
      FUNC_MUL: begin
        acc_nxt = '0;
      end
      FUNC_REM: begin
        opb_nxt     = in_b << sh_nxt;
        ctl_nxt.err = in_valid && b_zero;
        acc_nxt     = b_zero ? '0 : AW'(in_a);
      end
      default: begin
        acc_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opa_r <= in_a;
      opb_r <= opb_nxt;
      sh_r  <= sh_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/gf2alu_stage.sv =====
`timescale 1ns / 1ps
// one pipeline stage: a group of multiply-accumulate or shifted-xor reduction steps
// depends on gf2alu_pkg

module gf2alu_stage
  import gf2alu_pkg::*;
#(
  parameter int WIDTH = GF2ALU_WIDTH,
  parameter int FIRST = 0,
  parameter int STEPS = GF2ALU_STEPS_PER_STAGE,
  parameter int SHW   = $clog2(WIDTH),
  parameter int AW    = 2 * WIDTH - 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ctl_t             ctl_i,
  input  logic [WIDTH-1:0] opa_i,
  input  logic [WIDTH-1:0] opb_i,
  input  logic [SHW-1:0]   sh_i,
  input  logic [AW-1:0]    acc_i,
  output ctl_t             ctl_r,
  output logic [WIDTH-1:0] opa_r,
  output logic [WIDTH-1:0] opb_r,
  output logic [SHW-1:0]   sh_r,
  output logic [AW-1:0]    acc_r
);

  logic [AW-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_i;
    for (int s = 0; s < STEPS; s++) begin
      if (ctl_i.func == FUNC_MUL) begin
        // partial product for bit k of the multiplier
        if (opb_i[FIRST + s]) begin
          acc_nxt = acc_nxt ^ (AW'(opa_i) << (FIRST + s));
        end
      end else if (ctl_i.func == FUNC_REM) begin
        // cancel bit WIDTH-1-k with the divisor, while still at or above its degree
        if ((SHW'(FIRST + s) <= sh_i) && acc_nxt[WIDTH - 1 - (FIRST + s)]) begin
          acc_nxt = acc_nxt ^ (AW'(opb_i) >> (FIRST + s));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opa_r <= opa_i;
      opb_r <= opb_i;
      sh_r  <= sh_i;
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/gf2alu_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the gf2 polynomial alu, bound to the top level
// depends on gf2alu_pkg and gf2_polynomial_alu

module gf2alu_checker
  import gf2alu_pkg::*;
#(
  parameter int WIDTH = GF2ALU_WIDTH
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2*WIDTH-2:0] out_result,
  input logic               out_div_by_zero
);

  // a held result does not change
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_div_by_zero))
    else $error("held result changed");

  // an empty output slot never stalls the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // error results carry zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_result == '0)
    else $error("nonzero result on divide by zero");

  // error flag only on a real request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_div_by_zero |-> out_valid)
    else $error("error flag without a valid result");

endmodule

bind gf2_polynomial_alu gf2alu_checker #(
  .WIDTH (WIDTH)
) u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result      (out_result),
  .out_div_by_zero (out_div_by_zero)
);

// ===== sim/tb_gf2_polynomial_alu.sv =====
`timescale 1ns / 1ps
// self-checking testbench for gf2_polynomial_alu: directed rows, then random requests,
// with random idling on both channels; depends on gf2alu_pkg and the alu top level

module tb_gf2_polynomial_alu;
  import gf2alu_pkg::*;

  localparam int W = GF2ALU_WIDTH;
  localparam int N_DIRECTED = 23;
  localparam int N_RANDOM = 527;
  localparam int QUIET_LIMIT = 1000;   // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 8;     // pipe is 1 + ceil(W/8) deep
  localparam bit KNOWN = 1'b1;         // row carries its own expected result
  localparam bit PRED = 1'b0;          // row is checked against the predictor

  typedef struct packed {
    logic [2*W-2:0] result;
    logic           div_by_zero;
  } alu_result_t;

  typedef struct packed {
    func_t          func;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    bit             known;
    logic [2*W-2:0] res;
    logic           dbz;
  } alu_row_t;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     in_func = FUNC_ADD;
  logic [W-1:0]   in_a = '0;
  logic [W-1:0]   in_b = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [2*W-2:0] out_result;
  logic           out_div_by_zero;

  alu_result_t pending_results[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // directed rows: extremes, every operation, zero divisor, divisor one, unused code
  alu_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_ADD, 32'h0000_0000, 32'h0000_0000, KNOWN, 63'h0, 1'b0},
    '{FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, KNOWN, 63'h0, 1'b0},
    '{FUNC_ADD, 32'hffff_ffff, 32'h0000_0000, KNOWN, 63'hffff_ffff, 1'b0},
    '{FUNC_ADD, 32'ha5a5_a5a5, 32'h5a5a_5a5a, KNOWN, 63'hffff_ffff, 1'b0},
    '{FUNC_MUL, 32'h0000_0000, 32'hffff_ffff, KNOWN, 63'h0, 1'b0},
    '{FUNC_MUL, 32'hffff_ffff, 32'h0000_0001, KNOWN, 63'hffff_ffff, 1'b0},
    '{FUNC_MUL, 32'h0000_0001, 32'h8000_0000, KNOWN, 63'h8000_0000, 1'b0},
    '{FUNC_MUL, 32'h8000_0000, 32'h8000_0000, KNOWN, 63'h4000_0000_0000_0000, 1'b0},
    '{FUNC_MUL, 32'h0000_0003, 32'h0000_0003, KNOWN, 63'h5, 1'b0},
    '{FUNC_MUL, 32'hffff_ffff, 32'hffff_ffff, PRED, 63'h0, 1'b0},
    '{FUNC_MUL, 32'h1234_5678, 32'h9abc_def0, PRED, 63'h0, 1'b0},
    '{FUNC_REM, 32'h1234_5678, 32'h0000_0000, KNOWN, 63'h0, 1'b1},
    '{FUNC_REM, 32'hffff_ffff, 32'h0000_0000, KNOWN, 63'h0, 1'b1},
    '{FUNC_REM, 32'h0000_0000, 32'h0000_0000, KNOWN, 63'h0, 1'b1},
    '{FUNC_REM, 32'hffff_ffff, 32'h0000_0001, KNOWN, 63'h0, 1'b0},
    '{FUNC_REM, 32'h0000_0000, 32'h0000_0001, KNOWN, 63'h0, 1'b0},
    '{FUNC_REM, 32'hffff_ffff, 32'h8000_0000, KNOWN, 63'h7fff_ffff, 1'b0},
    '{FUNC_REM, 32'h8000_0000, 32'h8000_0000, KNOWN, 63'h0, 1'b0},
    '{FUNC_REM, 32'h0000_0007, 32'hffff_ffff, KNOWN, 63'h7, 1'b0},
    '{FUNC_REM, 32'hffff_ffff, 32'hffff_ffff, KNOWN, 63'h0, 1'b0},
    '{FUNC_REM, 32'hdead_beef, 32'h0000_011b, PRED, 63'h0, 1'b0},
    '{FUNC_RSV, 32'hffff_ffff, 32'hffff_ffff, KNOWN, 63'h0, 1'b0},
    '{FUNC_RSV, 32'h0000_0000, 32'h0000_0000, KNOWN, 63'h0, 1'b0}
  };

  gf2_polynomial_alu #(.WIDTH(W)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_a            (in_a),
    .in_b            (in_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result      (out_result),
    .out_div_by_zero (out_div_by_zero)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // expected alu output for one request
  function automatic alu_result_t gf2_alu_result(func_t f, logic [W-1:0] a, logic [W-1:0] b);
    alu_result_t    r;
    logic [2*W-2:0] prod;
    logic [W-1:0]   rest;
    int             deg;
    int             i;
    r = '0;
    case (f)
      FUNC_ADD: r.result = {{(W-1){1'b0}}, a ^ b};
      FUNC_MUL: begin
        // carry-less: xor in a shifted copy of a for every set bit of b
        prod = '0;
        for (i = 0; i < W; i++)
          if (b[i]) prod ^= ({{(W-1){1'b0}}, a} << i);
        r.result = prod;
      end
      FUNC_REM: begin
        if (b == '0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // degree of the divisor, then cancel leading terms from the top down
          deg = 0;
          for (i = 0; i < W; i++)
            if (b[i]) deg = i;
          rest = a;
          for (i = W - 1; i >= deg; i--)
            if (rest[i]) rest ^= (b << (i - deg));
          r.result = {{(W-1){1'b0}}, rest};
        end
      end
      default: ;  // unused code gives all zeros
    endcase
    return r;
  endfunction

  // random operand of varied shape: zero, all ones, one term, low degree, full
  function automatic logic [W-1:0] draw_poly();
    logic [W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W - 1);
      3, 4: v = v >> $urandom_range(1, W - 1);
      default: ;
    endcase
    return v;
  endfunction

  function automatic func_t draw_func();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return FUNC_RSV;
    if (r <= 5) return FUNC_ADD;
    if (r <= 10) return FUNC_MUL;
    return FUNC_REM;
  endfunction

  function automatic void note_mismatch(string field, logic [2*W-2:0] want, logic [2*W-2:0] got);
    $error("%s mismatch: expected %h, actual %h", field, want, got);
    fail_count++;
  endfunction

  // sender: random gap, then hold the request until it is taken
  bit send_burst = 1'b0;

  task automatic send_req(input func_t f, input logic [W-1:0] a, input logic [W-1:0] b,
                          input alu_result_t want);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_a     <= a;
    in_b     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: append to the expectation queue
    pending_results = {pending_results, want};
  endtask

  // stimulus and end of run
  initial begin
    alu_result_t want;
    func_t       f;
    logic [W-1:0] a;
    logic [W-1:0] b;
    int          n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (n = 0; n < N_DIRECTED; n++) begin
      if (directed_rows[n].known)
        want = '{result: directed_rows[n].res, div_by_zero: directed_rows[n].dbz};
      else
        want = gf2_alu_result(directed_rows[n].func, directed_rows[n].a, directed_rows[n].b);
      send_req(directed_rows[n].func, directed_rows[n].a, directed_rows[n].b, want);
    end

    // random requests
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // hold off until the pipe has drained completely
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      f = draw_func();
      a = draw_poly();
      b = draw_poly();
      send_req(f, a, b, gf2_alu_result(f, a, b));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[gf2_polynomial_alu] OK");
    else
      $display("[gf2_polynomial_alu] ERROR");
    $finish;
  end

  // receiver: random stall before each result, with stretches of none
  initial begin
    bit recv_burst;
    int stall;
    recv_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    alu_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: result %h, div_by_zero %b",
               out_result, out_div_by_zero);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result !== want.result)
          note_mismatch("out_result", want.result, out_result);
        if (out_div_by_zero !== want.div_by_zero)
          note_mismatch("out_div_by_zero", {{(2*W-2){1'b0}}, want.div_by_zero},
                        {{(2*W-2){1'b0}}, out_div_by_zero});
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[gf2_polynomial_alu] ERROR");
        $finish;
      end
    end
  end

endmodule
